// ----- hdl/i2cm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

   // transaction requests carried in the op field
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // slot index of the acknowledge bit within a byte
   localparam logic [3:0] ACK_SLOT = 4'd8;
   localparam logic [3:0] LAST_DATA_SLOT = 4'd7;
   localparam logic [1:0] LAST_QUARTER = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_START     = 4'd1,
      ST_RESTART   = 4'd2,
      ST_ADDR_WR   = 4'd3,
      ST_REG       = 4'd4,
      ST_WDATA     = 4'd5,
      ST_ADDR_RD   = 4'd6,
      ST_RDATA     = 4'd7,
      ST_STOP_OK   = 4'd8,
      ST_STOP_NACK = 4'd9
   } stage_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  dev_addr;
      logic [7:0]  reg_addr;
      logic [15:0] length;
      logic [7:0]  wr_data;
      logic        sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       wr_taken;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       done_res;
      logic       status;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- hdl/i2cm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [6:0]  dev_addr;
   logic [7:0]  reg_addr;
   logic [15:0] length;
   logic [7:0]  wr_data;
   logic        sda_in;

   modport source (
      output valid, op, dev_addr, reg_addr, length, wr_data, sda_in,
      input  ready
   );
   modport sink (
      input  valid, op, dev_addr, reg_addr, length, wr_data, sda_in,
      output ready
   );
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       wr_taken;
   logic [7:0] rd_data;
   logic       rd_valid;
   logic       done_res;
   logic       status;

   modport source (
      output valid, scl_out, sda_out, busy_res, wr_taken, rd_data, rd_valid,
             done_res, status,
      input  ready
   );
   modport sink (
      input  valid, scl_out, sda_out, busy_res, wr_taken, rd_data, rd_valid,
             done_res, status,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/i2cm_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire i2cm_pkg::req_word_type req,
   output i2cm_pkg::rsp_word_type     rsp
);

   i2cm_pkg::stage_type stage_ff, stage_in, stage_nx, cur_stage;
   logic [1:0]  quarter_ff, quarter_in, cur_q;
   logic [3:0]  bit_count_ff, bit_count_in, cur_bits;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] bytes_left_ff, bytes_left_in, cur_left;
   logic        read_mode_ff, read_mode_in, cur_read;
   logic [6:0]  held_addr_ff, held_addr_in, cur_addr;
   logic [7:0]  held_reg_ff, held_reg_in, cur_reg;
   logic        launch, last_q, ack_slot, left_le_one;

   // a request while idle turns this tick into quarter 0 of start
   always_comb begin
      launch    = (stage_ff == i2cm_pkg::ST_IDLE) &&
                  (req.op == i2cm_pkg::OP_WRITE || req.op == i2cm_pkg::OP_READ);
      cur_stage = launch ? i2cm_pkg::ST_START : stage_ff;
      cur_q     = launch ? 2'd0 : quarter_ff;
      cur_bits  = launch ? 4'd0 : bit_count_ff;
      cur_left  = launch ? req.length : bytes_left_ff;
      cur_read  = launch ? (req.op == i2cm_pkg::OP_READ) : read_mode_ff;
      cur_addr  = launch ? req.dev_addr : held_addr_ff;
      cur_reg   = launch ? req.reg_addr : held_reg_ff;
      last_q    = (cur_q == i2cm_pkg::LAST_QUARTER);
      ack_slot  = (cur_bits == i2cm_pkg::ACK_SLOT);
      left_le_one = (cur_left[15:1] == 15'd0);
   end

   // next stage, taken at the end of the last quarter
   always_comb begin
      stage_nx = cur_stage;
      case (cur_stage)
         i2cm_pkg::ST_IDLE:    stage_nx = i2cm_pkg::ST_IDLE;
         i2cm_pkg::ST_START:   stage_nx = i2cm_pkg::ST_ADDR_WR;
         i2cm_pkg::ST_RESTART: stage_nx = i2cm_pkg::ST_ADDR_RD;
         i2cm_pkg::ST_ADDR_WR, i2cm_pkg::ST_REG,
         i2cm_pkg::ST_WDATA, i2cm_pkg::ST_ADDR_RD: begin
            if (!ack_slot) begin
               stage_nx = cur_stage;
            end else if (cur_stage == i2cm_pkg::ST_ADDR_WR) begin
               stage_nx = req.sda_in ? i2cm_pkg::ST_STOP_NACK : i2cm_pkg::ST_REG;
            end else if (cur_stage == i2cm_pkg::ST_REG && cur_read) begin
               stage_nx = i2cm_pkg::ST_RESTART;
            end else if (cur_stage == i2cm_pkg::ST_ADDR_RD) begin
               stage_nx = (cur_left == 16'd0) ? i2cm_pkg::ST_STOP_OK
                                              : i2cm_pkg::ST_RDATA;
            end else begin
               stage_nx = (cur_left != 16'd0) ? i2cm_pkg::ST_WDATA
                                              : i2cm_pkg::ST_STOP_OK;
            end
         end
         i2cm_pkg::ST_RDATA: begin
            if (ack_slot && left_le_one) begin
               stage_nx = i2cm_pkg::ST_STOP_OK;
            end else begin
               stage_nx = i2cm_pkg::ST_RDATA;
            end
         end
         i2cm_pkg::ST_STOP_OK, i2cm_pkg::ST_STOP_NACK: stage_nx = i2cm_pkg::ST_IDLE;
         default: stage_nx = i2cm_pkg::ST_IDLE;
      endcase

      if (cur_stage == i2cm_pkg::ST_IDLE) begin
         stage_in   = i2cm_pkg::ST_IDLE;
         quarter_in = 2'd0;
      end else if (last_q) begin
         stage_in   = stage_nx;
         quarter_in = 2'd0;
      end else begin
         stage_in   = cur_stage;
         quarter_in = cur_q + 2'd1;
      end
   end

   // line levels, flags and datapath
   always_comb begin
      rsp           = '0;
      rsp.scl_out   = 1'b1;
      rsp.sda_out   = 1'b1;
      rsp.busy_res  = 1'b1;
      bit_count_in  = cur_bits;
      shift_in      = shift_ff;
      bytes_left_in = cur_left;
      read_mode_in  = cur_read;
      held_addr_in  = cur_addr;
      held_reg_in   = cur_reg;

      case (cur_stage)
         i2cm_pkg::ST_IDLE: begin
            rsp.busy_res = 1'b0;
         end
         i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
            rsp.scl_out = (cur_stage == i2cm_pkg::ST_START) || (cur_q != 2'd0);
            rsp.sda_out = ~cur_q[1];
            if (last_q) begin
               bit_count_in = 4'd0;
               shift_in     = {cur_addr, (cur_stage == i2cm_pkg::ST_RESTART)};
            end
         end
         i2cm_pkg::ST_ADDR_WR, i2cm_pkg::ST_REG,
         i2cm_pkg::ST_WDATA, i2cm_pkg::ST_ADDR_RD: begin
            rsp.scl_out = cur_q[1];
            rsp.sda_out = ack_slot ? 1'b1 : shift_ff[7];
            if (last_q) begin
               if (!ack_slot) begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = cur_bits + 4'd1;
               end else begin
                  bit_count_in = 4'd0;
                  if (cur_stage == i2cm_pkg::ST_ADDR_WR) begin
                     if (!req.sda_in) begin
                        shift_in = cur_reg;
                     end
                  end else if (cur_stage == i2cm_pkg::ST_REG && cur_read) begin
                     shift_in = shift_ff;
                  end else if (cur_stage == i2cm_pkg::ST_ADDR_RD) begin
                     shift_in = 8'd0;
                  end else if (cur_left != 16'd0) begin
                     // load the next write word
                     shift_in      = req.wr_data;
                     bytes_left_in = cur_left - 16'd1;
                     rsp.wr_taken  = 1'b1;
                  end
               end
            end
         end
         i2cm_pkg::ST_RDATA: begin
            rsp.scl_out = cur_q[1];
            // ack every byte but the last
            rsp.sda_out = ack_slot ? left_le_one : 1'b1;
            if (last_q) begin
               if (!ack_slot) begin
                  shift_in     = {shift_ff[6:0], req.sda_in};
                  bit_count_in = cur_bits + 4'd1;
                  if (cur_bits == i2cm_pkg::LAST_DATA_SLOT) begin
                     rsp.rd_data  = {shift_ff[6:0], req.sda_in};
                     rsp.rd_valid = 1'b1;
                  end
               end else begin
                  bit_count_in  = 4'd0;
                  shift_in      = 8'd0;
                  bytes_left_in = (cur_left != 16'd0) ? cur_left - 16'd1 : 16'd0;
               end
            end
         end
         i2cm_pkg::ST_STOP_OK, i2cm_pkg::ST_STOP_NACK: begin
            rsp.scl_out = (cur_q != 2'd0);
            rsp.sda_out = cur_q[1];
            if (last_q) begin
               rsp.done_res = 1'b1;
               rsp.status   = (cur_stage == i2cm_pkg::ST_STOP_NACK);
            end
         end
         default: begin
            rsp.busy_res = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= i2cm_pkg::ST_IDLE;
         quarter_ff    <= 2'd0;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         bytes_left_ff <= 16'd0;
         read_mode_ff  <= 1'b0;
         held_addr_ff  <= 7'd0;
         held_reg_ff   <= 8'd0;
      end else if (step) begin
         stage_ff      <= stage_in;
         quarter_ff    <= quarter_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         read_mode_ff  <= read_mode_in;
         held_addr_ff  <= held_addr_in;
         held_reg_ff   <= held_reg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/i2c_master_register_access.sv -----
// i2c master for register writes and reads, driven one quarter-bit tick per word
//
// req_bus: one word per tick; op starts a write or a read while idle and is
//   ignored otherwise; sda_in is the line level sampled at the end of the tick
// rsp_bus: one word per request word, in order, giving the scl/sda drive for
//   that tick, busy, wr_taken, read data with rd_valid, and done with status
// a word is taken when valid and ready are both high on a rising clock edge
//
// flow: the request word is registered on acceptance, then the line state
// machine advances and the response is registered once the response register
// is empty or rsp ready is high; one word per cycle sustained while rsp ready
// stays high, as the phase machine updates once per word
// stalls: the input register and the response register each hold one word;
// while rsp ready is low the response holds and the request side takes at
// most one more word before ready drops
// reset (synchronous, active high) empties both registers and returns the
// machine to idle with all counters and held fields cleared
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_access (
   input  wire logic clock,
   input  wire logic reset,
   i2cm_req_if.sink  req_bus,
   i2cm_rsp_if.source rsp_bus
);

   i2cm_pkg::req_word_type req_ff, req_in;
   i2cm_pkg::rsp_word_type rsp_ff, core_rsp;
   logic req_valid_ff, req_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;

   always_comb begin
      req_in.op       = req_bus.op;
      req_in.dev_addr = req_bus.dev_addr;
      req_in.reg_addr = req_bus.reg_addr;
      req_in.length   = req_bus.length;
      req_in.wr_data  = req_bus.wr_data;
      req_in.sda_in   = req_bus.sda_in;
      req_valid_in    = (req_bus.valid && req_bus.ready) || (req_valid_ff && !advance);
      rsp_valid_in    = advance || (rsp_valid_ff && !rsp_bus.ready);
   end

   i2cm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.scl_out  = rsp_ff.scl_out;
   assign rsp_bus.sda_out  = rsp_ff.sda_out;
   assign rsp_bus.busy_res = rsp_ff.busy_res;
   assign rsp_bus.wr_taken = rsp_ff.wr_taken;
   assign rsp_bus.rd_data  = rsp_ff.rd_data;
   assign rsp_bus.rd_valid = rsp_ff.rd_valid;
   assign rsp_bus.done_res = rsp_ff.done_res;
   assign rsp_bus.status   = rsp_ff.status;

endmodule

`default_nettype wire

// ----- dv/tb_i2c_master_register_access.sv -----
`timescale 1ns / 1ps

class i2c_tick_scoreboard;
   // copy of the line phase machine
   logic [5:0]  phase;
   logic [3:0]  bit_count;
   logic [7:0]  shift_byte;
   logic [15:0] bytes_left;
   logic        read_mode;
   logic [6:0]  held_addr;
   logic [7:0]  held_reg;

   i2cm_pkg::rsp_word_type line_q[$];
   int errors;

   function new();
      phase = '0;
      bit_count = '0;
      shift_byte = '0;
      bytes_left = '0;
      read_mode = 1'b0;
      held_addr = '0;
      held_reg = '0;
      errors = 0;
   endfunction

   function i2cm_pkg::rsp_word_type predict_tick(i2cm_pkg::req_word_type w);
      i2cm_pkg::rsp_word_type r;
      logic [3:0] stg;
      logic [3:0] nxt;
      logic [1:0] q;
      stg = phase[5:2];
      q = phase[1:0];
      r = '0;
      r.scl_out = 1'b1;
      r.sda_out = 1'b1;
      r.busy_res = 1'b1;
      nxt = stg;
      if (stg == i2cm_pkg::ST_IDLE || stg > i2cm_pkg::ST_STOP_NACK) begin
         if (w.op == i2cm_pkg::OP_WRITE || w.op == i2cm_pkg::OP_READ) begin
            held_addr = w.dev_addr;
            held_reg = w.reg_addr;
            bytes_left = w.length;
            read_mode = (w.op == i2cm_pkg::OP_READ);
            bit_count = '0;
            stg = i2cm_pkg::ST_START;
            q = 2'd0;
            nxt = stg;
         end else begin
            phase = '0;
            r.busy_res = 1'b0;
            return r;
         end
      end
      case (stg)
         i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
            r.scl_out = (stg == i2cm_pkg::ST_START || q != 2'd0);
            r.sda_out = (q < 2'd2);
            if (q == i2cm_pkg::LAST_QUARTER) begin
               bit_count = '0;
               if (stg == i2cm_pkg::ST_START) begin
                  shift_byte = {held_addr, 1'b0};
                  nxt = i2cm_pkg::ST_ADDR_WR;
               end else begin
                  shift_byte = {held_addr, 1'b1};
                  nxt = i2cm_pkg::ST_ADDR_RD;
               end
            end
         end
         i2cm_pkg::ST_ADDR_WR, i2cm_pkg::ST_REG,
         i2cm_pkg::ST_WDATA, i2cm_pkg::ST_ADDR_RD: begin
            r.scl_out = (q >= 2'd2);
            r.sda_out = (bit_count < i2cm_pkg::ACK_SLOT) ? shift_byte[7] : 1'b1;
            if (q == i2cm_pkg::LAST_QUARTER) begin
               if (bit_count < i2cm_pkg::ACK_SLOT) begin
                  shift_byte = {shift_byte[6:0], 1'b0};
                  bit_count = bit_count + 4'd1;
               end else begin
                  bit_count = '0;
                  if (stg == i2cm_pkg::ST_ADDR_WR) begin
                     if (w.sda_in) begin
                        nxt = i2cm_pkg::ST_STOP_NACK;
                     end else begin
                        shift_byte = held_reg;
                        nxt = i2cm_pkg::ST_REG;
                     end
                  end else if (stg == i2cm_pkg::ST_REG && read_mode) begin
                     nxt = i2cm_pkg::ST_RESTART;
                  end else if (stg == i2cm_pkg::ST_ADDR_RD) begin
                     shift_byte = '0;
                     nxt = (bytes_left == 0) ? i2cm_pkg::ST_STOP_OK : i2cm_pkg::ST_RDATA;
                  end else if (bytes_left != 0) begin
                     // load the next write byte
                     shift_byte = w.wr_data;
                     bytes_left = bytes_left - 16'd1;
                     r.wr_taken = 1'b1;
                     nxt = i2cm_pkg::ST_WDATA;
                  end else begin
                     nxt = i2cm_pkg::ST_STOP_OK;
                  end
               end
            end
         end
         i2cm_pkg::ST_RDATA: begin
            r.scl_out = (q >= 2'd2);
            r.sda_out = (bit_count < i2cm_pkg::ACK_SLOT) ? 1'b1 : (bytes_left <= 16'd1);
            if (q == i2cm_pkg::LAST_QUARTER) begin
               if (bit_count < i2cm_pkg::ACK_SLOT) begin
                  shift_byte = {shift_byte[6:0], w.sda_in};
                  if (bit_count == i2cm_pkg::LAST_DATA_SLOT) begin
                     r.rd_data = shift_byte;
                     r.rd_valid = 1'b1;
                  end
                  bit_count = bit_count + 4'd1;
               end else begin
                  bit_count = '0;
                  if (bytes_left != 0)
                     bytes_left = bytes_left - 16'd1;
                  shift_byte = '0;
                  nxt = (bytes_left == 0) ? i2cm_pkg::ST_STOP_OK : i2cm_pkg::ST_RDATA;
               end
            end
         end
         default: begin
            r.scl_out = (q != 2'd0);
            r.sda_out = (q >= 2'd2);
            if (q == i2cm_pkg::LAST_QUARTER) begin
               r.done_res = 1'b1;
               r.status = (stg == i2cm_pkg::ST_STOP_NACK);
               nxt = i2cm_pkg::ST_IDLE;
            end
         end
      endcase
      if (q == i2cm_pkg::LAST_QUARTER)
         phase = {nxt, 2'b00};
      else
         phase = {stg, q + 2'd1};
      return r;
   endfunction

   function void note_request(i2cm_pkg::req_word_type w);
      line_q.push_back(predict_tick(w));
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_response(i2cm_pkg::rsp_word_type got);
      i2cm_pkg::rsp_word_type want;
      if (line_q.size() == 0) begin
         $display("%0t response word with nothing expected: actual %p", $time, got);
         errors++;
         return;
      end
      want = line_q.pop_front();
      compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("wr_taken", 8'(want.wr_taken), 8'(got.wr_taken));
      compare_field("rd_data", want.rd_data, got.rd_data);
      compare_field("rd_valid", 8'(want.rd_valid), 8'(got.rd_valid));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("status", 8'(want.status), 8'(got.status));
   endfunction
endclass

module tb_i2c_master_register_access;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int ADDR_ACK_TICK = 39;
   localparam int NACK_TICKS = 44;
   localparam int RANDOM_WORDS = 100;
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_if ();
   i2cm_rsp_if rsp_if ();

   i2c_master_register_access i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   i2c_tick_scoreboard sb = new();

   int burst_left = 0;
   int sent_words = 0;
   int accepted_rsp = 0;
   int idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // accepted words on both channels, plus the stall watchdog
   always @(posedge clock) begin
      i2cm_pkg::req_word_type rq;
      i2cm_pkg::rsp_word_type rs;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_if.valid && req_if.ready) begin
            rq.op = req_if.op;
            rq.dev_addr = req_if.dev_addr;
            rq.reg_addr = req_if.reg_addr;
            rq.length = req_if.length;
            rq.wr_data = req_if.wr_data;
            rq.sda_in = req_if.sda_in;
            sb.note_request(rq);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rs.scl_out = rsp_if.scl_out;
            rs.sda_out = rsp_if.sda_out;
            rs.busy_res = rsp_if.busy_res;
            rs.wr_taken = rsp_if.wr_taken;
            rs.rd_data = rsp_if.rd_data;
            rs.rd_valid = rsp_if.rd_valid;
            rs.done_res = rsp_if.done_res;
            rs.status = rsp_if.status;
            sb.check_response(rs);
            accepted_rsp++;
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver: segments of varying ready density, one long hold-off
   initial begin
      int seg;
      int mode;
      bit held;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         if (!held && accepted_rsp >= HOLD_AFTER) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            held = 1'b1;
         end
         mode = $urandom_range(0, 3);
         seg = $urandom_range(4, 60);
         repeat (seg) begin
            @(negedge clock);
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 4) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   function automatic i2cm_pkg::req_word_type random_word(logic [1:0] op);
      i2cm_pkg::req_word_type w;
      w.op = op;
      w.dev_addr = 7'($urandom);
      w.reg_addr = 8'($urandom);
      w.length = 16'($urandom);
      w.wr_data = 8'($urandom);
      w.sda_in = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_word(input i2cm_pkg::req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_if.valid <= 1'b1;
      req_if.op <= w.op;
      req_if.dev_addr <= w.dev_addr;
      req_if.reg_addr <= w.reg_addr;
      req_if.length <= w.length;
      req_if.wr_data <= w.wr_data;
      req_if.sda_in <= w.sda_in;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      sent_words++;
      @(negedge clock);
   endtask

   task automatic run_idle(input int n);
      repeat (n) push_word(random_word($urandom_range(0, 1) ? i2cm_pkg::OP_TICK : OP_SPARE));
   endtask

   // start word, then exactly as many ticks as the transfer lasts, with
   // random ops that the busy master must ignore
   task automatic run_transfer(input logic [1:0] op, input logic [6:0] dev,
                               input logic [7:0] regb, input logic [15:0] len,
                               input bit nack);
      i2cm_pkg::req_word_type w;
      int total;
      w = random_word(op);
      w.dev_addr = dev;
      w.reg_addr = regb;
      w.length = len;
      push_word(w);
      if (nack)
         total = NACK_TICKS;
      else if (op == i2cm_pkg::OP_WRITE)
         total = 80 + 36 * int'(len);
      else
         total = 120 + 36 * int'(len);
      for (int t = 1; t < total; t++) begin
         w = random_word(2'($urandom_range(0, 3)));
         if (t == ADDR_ACK_TICK)
            w.sda_in = nack;
         push_word(w);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.line_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      int start_count;
      int pick;
      logic [1:0] op;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = i2cm_pkg::OP_TICK;
      req_if.dev_addr = '0;
      req_if.reg_addr = '0;
      req_if.length = '0;
      req_if.wr_data = '0;
      req_if.sda_in = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: idle with both tick-only codes, extremes, short and empty transfers, address nacks
      push_word(random_word(OP_SPARE));
      push_word(random_word(i2cm_pkg::OP_TICK));
      run_transfer(i2cm_pkg::OP_WRITE, 7'h7F, 8'hFF, 16'd1, 1'b0);
      run_transfer(i2cm_pkg::OP_WRITE, 7'h00, 8'h00, 16'd0, 1'b0);
      run_transfer(i2cm_pkg::OP_READ, 7'h55, 8'hA5, 16'd2, 1'b0);
      run_transfer(i2cm_pkg::OP_READ, 7'h2A, 8'h5A, 16'd0, 1'b0);
      run_transfer(i2cm_pkg::OP_WRITE, 7'h7F, 8'h00, 16'hFFFF, 1'b1);
      run_transfer(i2cm_pkg::OP_READ, 7'h00, 8'hFF, 16'hFFFF, 1'b1);
      run_idle(2);
      wait_drained();

      // random: mostly well formed transfers, some address nacks and idle noise
      start_count = sent_words;
      while (sent_words - start_count < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         op = $urandom_range(0, 1) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
         if (pick < 8)
            run_transfer(op, 7'($urandom), 8'($urandom),
                         16'(($urandom_range(0, 7) == 0) ? $urandom_range(3, 8)
                                                         : $urandom_range(0, 2)),
                         1'b0);
         else if (pick == 8)
            run_transfer(op, 7'($urandom), 8'($urandom), 16'($urandom), 1'b1);
         else
            run_idle($urandom_range(1, 12));
         run_idle($urandom_range(0, 4));
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.line_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/i2cm_pkg.sv
hdl/i2cm_if.sv
hdl/i2cm_core.sv
hdl/i2c_master_register_access.sv
dv/tb_i2c_master_register_access.sv
